>>> hw/rtl/fib_pkg.sv
// Shared constants, codes and types of the frame inbox.
package fib_pkg;

   localparam int OP_W       = 2;
   localparam int FLEN_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int OFF_W      = 11;
   localparam int LEN_W      = 12;
   localparam int SLOT_OUT_W = 4;
   localparam int DROP_W     = 32;
   localparam int SU_W       = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam int LEN_MAX = (1 << LEN_W) - 1;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
   localparam logic [OP_W-1:0] OP_RECV  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS   = 1'd1;

   localparam logic [LEN_W-1:0] MAX_LEN_RST = 12'd2048;
   localparam logic [SU_W-1:0]  SLOTS_RST   = 5'd16;

   // Request in flight while its memory reads complete.
   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic                  got;
      logic [SLOT_OUT_W-1:0] slot;
      logic [OFF_W-1:0]      roff;
      logic                  rok;
      logic                  acc;
      logic [DROP_W-1:0]     drop;
   } stage_type;

endpackage

>>> hw/rtl/frame_inbox_with_borrow_release_unit.sv
// Frame inbox with borrow-and-release receive: top level.
// The memory read and the request stage load when a request is accepted; the output
// register loads from them when the stage moves on.
// Throughput: one request per cycle while req_stall is low; req_stall is raised while the
// stage and output register are full and the output is stalled. Each request uses at most
// one port of each memory. Reset clears pointers, counters, fill and borrow state and the
// valid bits, and loads configuration defaults; data registers and memories are not cleared.
module frame_inbox_with_borrow_release_unit #(
   parameter int SLOTS      = 16,
   parameter int SLOT_BYTES = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fib_pkg::OP_W-1:0]         req_op,
   input  logic [fib_pkg::FLEN_W-1:0]       req_frame_len,
   input  logic [fib_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic [fib_pkg::OFF_W-1:0]        req_read_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_got_frame,
   output logic [fib_pkg::SLOT_OUT_W-1:0]   rsp_frame_slot,
   output logic [fib_pkg::LEN_W-1:0]        rsp_out_len,
   output logic [fib_pkg::BYTE_W-1:0]       rsp_read_byte,
   output logic                             rsp_accepted,
   output logic [fib_pkg::DROP_W-1:0]       rsp_dropped_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fib_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fib_pkg::CSR_DATA_W-1:0]   csr_data
);

   import fib_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DEP_W  = $clog2(SLOTS + 1);
   localparam int CW0    = (SLOT_W + 1 > DEP_W) ? SLOT_W + 1 : DEP_W;
   localparam int CW     = (CW0 > SU_W) ? CW0 : SU_W;
   localparam int STORE  = SLOTS * SLOT_BYTES;
   localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int LIM    = (SLOT_BYTES > LEN_MAX) ? LEN_MAX : SLOT_BYTES;

   // Control and configuration state
   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic [SU_W-1:0]   slots_use_ff, slots_use_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [DEP_W-1:0]  pending_ff, pending_in;
   logic [DEP_W-1:0]  unread_ff, unread_in;
   logic              fill_active_ff, fill_active_in;
   logic [LEN_W-1:0]  fill_len_ff, fill_len_in;
   logic [LEN_W-1:0]  fill_pos_ff, fill_pos_in;
   logic              borrow_valid_ff, borrow_valid_in;
   logic [SLOT_W-1:0] borrow_slot_ff, borrow_slot_in;
   logic [DROP_W-1:0] drop_ff, drop_in;

   // Pipeline
   logic              p_valid_ff, p_valid_in;
   stage_type         p_ff, p_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_got_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_acc_ff;
   logic [DROP_W-1:0] rsp_drop_ff;

   // Memory ports
   logic              pay_we, pay_re;
   logic [ADDR_W-1:0] pay_waddr, pay_raddr;
   logic [BYTE_W-1:0] pay_rdata;
   logic              len_we, len_re;
   logic [SLOT_W-1:0] len_waddr, len_raddr;
   logic [LEN_W-1:0]  len_wdata;
   logic [LEN_W-1:0]  len_rdata;

   logic              accept, move;
   logic [CW-1:0]     su_ext, depth;
   logic [CW-1:0]     tail_inc, head_inc;
   logic [SLOT_W-1:0] tail_nx, head_nx;
   logic [LEN_W-1:0]  limit;
   logic              roff_in_slot;
   logic [SLOT_OUT_W+SLOT_W-1:0] slot_wide;

   assign csr_ready = 1'b1;

   assign move      = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Effective depth and modulo slot stepping
   always_comb begin
      su_ext   = CW'(slots_use_ff);
      if (su_ext == '0) begin
         depth = CW'(1);
      end else if (su_ext > CW'(SLOTS)) begin
         depth = CW'(SLOTS);
      end else begin
         depth = su_ext;
      end
      tail_inc = CW'(tail_ff) + CW'(1);
      head_inc = CW'(head_ff) + CW'(1);
      tail_nx  = (tail_inc >= depth) ? '0 : tail_inc[SLOT_W-1:0];
      head_nx  = (head_inc >= depth) ? '0 : head_inc[SLOT_W-1:0];
      limit    = (max_len_ff > LEN_W'(LIM)) ? LEN_W'(LIM) : max_len_ff;
   end

   assign roff_in_slot = 32'(req_read_offset) < 32'(SLOT_BYTES);
   assign slot_wide    = {{SLOT_OUT_W{1'b0}}, head_ff};

   // Request processing
   always_comb begin
      tail_in         = tail_ff;
      head_in         = head_ff;
      pending_in      = pending_ff;
      unread_in       = unread_ff;
      fill_active_in  = fill_active_ff;
      fill_len_in     = fill_len_ff;
      fill_pos_in     = fill_pos_ff;
      borrow_valid_in = borrow_valid_ff;
      borrow_slot_in  = borrow_slot_ff;
      drop_in         = drop_ff;

      pay_we    = 1'b0;
      pay_waddr = ADDR_W'(tail_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(fill_pos_ff);
      pay_re    = 1'b0;
      pay_raddr = ADDR_W'(borrow_slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(req_read_offset);
      len_we    = 1'b0;
      len_waddr = tail_ff;
      len_wdata = fill_len_ff;
      len_re    = 1'b0;
      len_raddr = borrow_slot_ff;

      p_in      = '0;
      p_in.op   = req_op;
      p_in.roff = req_read_offset;

      if (accept) begin
         unique case (req_op)
            OP_START: begin
               fill_active_in = 1'b0;
               fill_len_in    = '0;
               fill_pos_in    = '0;
               if (32'(req_frame_len) > 32'(limit) || 32'(pending_ff) >= 32'(depth)) begin
                  if (drop_ff != '1) begin
                     drop_in = drop_ff + DROP_W'(1);
                  end
               end else begin
                  p_in.acc = 1'b1;
                  if (req_frame_len == '0) begin
                     // empty frame commits at once
                     len_we     = 1'b1;
                     len_wdata  = '0;
                     tail_in    = tail_nx;
                     pending_in = pending_ff + DEP_W'(1);
                     unread_in  = unread_ff + DEP_W'(1);
                  end else begin
                     fill_active_in = 1'b1;
                     fill_len_in    = req_frame_len[LEN_W-1:0];
                  end
               end
            end
            OP_DATA: begin
               if (fill_active_ff && fill_pos_ff < fill_len_ff) begin
                  pay_we      = 1'b1;
                  fill_pos_in = fill_pos_ff + LEN_W'(1);
                  if (fill_pos_ff + LEN_W'(1) >= fill_len_ff) begin
                     len_we         = 1'b1;
                     tail_in        = tail_nx;
                     pending_in     = pending_ff + DEP_W'(1);
                     unread_in      = unread_ff + DEP_W'(1);
                     fill_active_in = 1'b0;
                     fill_len_in    = '0;
                     fill_pos_in    = '0;
                  end
               end
            end
            OP_RECV: begin
               // release the previous borrow first
               if (borrow_valid_ff) begin
                  borrow_valid_in = 1'b0;
                  if (pending_ff != '0) begin
                     pending_in = pending_ff - DEP_W'(1);
                  end
               end
               if (unread_ff != '0) begin
                  p_in.got        = 1'b1;
                  p_in.slot       = slot_wide[SLOT_OUT_W-1:0];
                  len_re          = 1'b1;
                  len_raddr       = head_ff;
                  borrow_valid_in = 1'b1;
                  borrow_slot_in  = head_ff;
                  head_in         = head_nx;
                  unread_in       = unread_ff - DEP_W'(1);
               end
            end
            OP_READ: begin
               len_re   = 1'b1;
               pay_re   = roff_in_slot;
               p_in.rok = borrow_valid_ff && roff_in_slot;
            end
            default: begin
            end
         endcase
      end
      p_in.drop = drop_in;
   end

   // Configuration writes
   always_comb begin
      max_len_in   = max_len_ff;
      slots_use_in = slots_use_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_LEN: max_len_in   = csr_data[LEN_W-1:0];
            CSR_SLOTS:   slots_use_in = csr_data[SU_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign p_valid_in   = accept ? 1'b1 : (move ? 1'b0 : p_valid_ff);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff      <= MAX_LEN_RST;
         slots_use_ff    <= SLOTS_RST;
         tail_ff         <= '0;
         head_ff         <= '0;
         pending_ff      <= '0;
         unread_ff       <= '0;
         fill_active_ff  <= 1'b0;
         fill_len_ff     <= '0;
         fill_pos_ff     <= '0;
         borrow_valid_ff <= 1'b0;
         borrow_slot_ff  <= '0;
         drop_ff         <= '0;
         p_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         max_len_ff      <= max_len_in;
         slots_use_ff    <= slots_use_in;
         tail_ff         <= tail_in;
         head_ff         <= head_in;
         pending_ff      <= pending_in;
         unread_ff       <= unread_in;
         fill_active_ff  <= fill_active_in;
         fill_len_ff     <= fill_len_in;
         fill_pos_ff     <= fill_pos_in;
         borrow_valid_ff <= borrow_valid_in;
         borrow_slot_ff  <= borrow_slot_in;
         drop_ff         <= drop_in;
         p_valid_ff      <= p_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers: hold the stage while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff <= p_in;
      end
      if (move) begin
         rsp_got_ff  <= p_ff.got;
         rsp_slot_ff <= p_ff.slot;
         rsp_len_ff  <= p_ff.got ? len_rdata : '0;
         rsp_byte_ff <= (p_ff.op == OP_READ && p_ff.rok && LEN_W'(p_ff.roff) < len_rdata)
                        ? pay_rdata : '0;
         rsp_acc_ff  <= p_ff.acc;
         rsp_drop_ff <= p_ff.drop;
      end
   end

   fib_mem #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE)
   ) u_payload (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (req_data_byte),
      .rd_en   (pay_re),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   fib_mem #(
      .WIDTH (LEN_W),
      .DEPTH (SLOTS)
   ) u_lengths (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_en   (len_re),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_got_frame     = rsp_got_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_out_len       = rsp_len_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_dropped_count = rsp_drop_ff;

endmodule

>>> hw/rtl/fib_mem.sv
// Simple dual-port memory: one write port, one registered read port.
module fib_mem #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
